>>> hw/rtl/cqs_pkg.sv
package cqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int CMD_W     = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_PEEK,
    CMD_SEARCH,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_NOTFOUND
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

endpackage

>>> hw/rtl/cqs_cell.sv
module cqs_cell #(
  parameter int  IDX     = 0,
  parameter int  PW      = 1,
  parameter int  XW      = 2,
  parameter type probe_t = logic,
  parameter type wave_t  = logic
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [PW-1:0]               wr_slot,
  input  logic [cqs_pkg::DATA_W-1:0]  wr_data,
  input  probe_t                      probe,
  input  wave_t                       wave_in,
  output wave_t                       wave_out
);

  logic [cqs_pkg::DATA_W-1:0] data;
  logic [XW-1:0]              me;
  logic                       hit;
  logic                       in_up;
  logic                       in_lo;
  wave_t                      wave_next;

  assign me = XW'(IDX);

  always_comb begin
    hit       = probe.match_all || (data == probe.key);
    in_up     = (me >= probe.head) && (me < probe.up_hi);
    in_lo     = (me < probe.lo_hi);
    wave_next = wave_in;
    if (!wave_in.uf && in_up && hit) begin
      wave_next.uf = 1'b1;
      wave_next.us = PW'(IDX);
      wave_next.ud = data;
    end
    if (!wave_in.lf && in_lo && hit) begin
      wave_next.lf = 1'b1;
      wave_next.ls = PW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_slot == PW'(IDX))) begin
      data <= wr_data;
    end
    wave_out <= wave_next;
  end

endmodule

>>> hw/rtl/circular_queue_with_search_core.sv
// enqueue, clear, unknown command, and dequeue or peek on an empty queue: request goes to
// S_FIN; search, and dequeue or peek on a held entry: S_WALK first, one pass of the probe
// through the row of DEPTH slot cells; result registered from S_FIN once output is free
// one request in flight at a time: the next is taken once the last has left S_FIN,
// also while the result still waits; slot contents are not cleared by reset
// synchronous reset clears pointers, count, control and output valid, sets capacity to DEPTH
module circular_queue_with_search_core #(
  parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [cqs_pkg::CAP_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cqs_pkg::CMD_W-1:0]           command,
  input  logic signed [cqs_pkg::DATA_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cqs_pkg::STATUS_W-1:0]        status,
  output logic signed [cqs_pkg::DATA_W-1:0]   data_out,
  output logic [$clog2(DEPTH)-1:0]            match_slot,
  output logic [$clog2(DEPTH+1)-1:0]          entry_count,
  output logic                                is_empty,
  output logic                                is_full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int RW = (CW > cqs_pkg::CAP_W) ? CW : cqs_pkg::CAP_W;
  localparam int XW = RW + 1;

  typedef struct packed {
    logic [cqs_pkg::DATA_W-1:0] key;
    logic                       match_all;
    logic [XW-1:0]              head;
    logic [XW-1:0]              up_hi;
    logic [XW-1:0]              lo_hi;
  } probe_t;

  typedef struct packed {
    logic                       uf;
    logic [PW-1:0]              us;
    logic [cqs_pkg::DATA_W-1:0] ud;
    logic                       lf;
    logic [PW-1:0]              ls;
  } wave_t;

  cqs_pkg::state_t  state, state_next;
  cqs_pkg::cmd_t    cmd_in;
  cqs_pkg::cmd_t    cmd_q;
  logic [cqs_pkg::DATA_W-1:0] value_q;
  logic [RW-1:0]    capacity;
  logic [XW-1:0]    eff_cap;
  logic [PW-1:0]    head, head_next;
  logic [PW-1:0]    tail, tail_next;
  logic [CW-1:0]    held, held_next;
  logic [PW-1:0]    walk_cnt, walk_cnt_next;
  logic             accept;
  logic             wr_en;
  logic             load_out;
  probe_t           probe, probe_next;
  wave_t            wave [DEPTH+1];

  logic [XW-1:0]    head_x, cnt_x, up_end, up_len, up_take, up_hi, rem, lo_hi;

  cqs_pkg::status_t           res_status;
  logic [cqs_pkg::DATA_W-1:0] res_data;
  logic [PW-1:0]              res_slot;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [XW-1:0] cap);
    logic [XW-1:0] n;
    n = XW'(p) + XW'(1);
    advance = (n >= cap) ? '0 : PW'(n);
  endfunction

  assign cmd_in   = cqs_pkg::cmd_t'(command);
  assign in_stall = (state != cqs_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = XW'(1);
    end else if (XW'(capacity) > XW'(DEPTH)) begin
      eff_cap = XW'(DEPTH);
    end else begin
      eff_cap = XW'(capacity);
    end
  end

  // held entries split into the run from head up to the wrap point and the run from slot 0
  always_comb begin
    head_x  = XW'(head);
    cnt_x   = XW'(held);
    up_end  = (head_x < eff_cap) ? eff_cap : head_x + XW'(1);
    up_len  = up_end - head_x;
    up_take = (cnt_x < up_len) ? cnt_x : up_len;
    up_hi   = head_x + up_take;
    rem     = cnt_x - up_take;
    lo_hi   = (rem < eff_cap) ? rem : eff_cap;

    probe_next.key  = value;
    probe_next.head = head_x;
    if (cmd_in == cqs_pkg::CMD_SEARCH) begin
      probe_next.match_all = 1'b0;
      probe_next.up_hi     = up_hi;
      probe_next.lo_hi     = lo_hi;
    end else begin
      probe_next.match_all = 1'b1;
      probe_next.up_hi     = head_x + XW'(1);
      probe_next.lo_hi     = '0;
    end
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    held_next     = held;
    walk_cnt_next = walk_cnt;
    wr_en         = 1'b0;
    load_out      = 1'b0;
    res_status    = cqs_pkg::ST_OK;
    res_data      = '0;
    res_slot      = '0;
    case (state)
      cqs_pkg::S_IDLE: begin
        if (in_valid) begin
          walk_cnt_next = '0;
          case (cmd_in)
            cqs_pkg::CMD_SEARCH: state_next = cqs_pkg::S_WALK;
            cqs_pkg::CMD_DEQ, cqs_pkg::CMD_PEEK: begin
              state_next = (held == '0) ? cqs_pkg::S_FIN : cqs_pkg::S_WALK;
            end
            default: state_next = cqs_pkg::S_FIN;
          endcase
        end
      end
      cqs_pkg::S_WALK: begin
        walk_cnt_next = walk_cnt + PW'(1);
        if (walk_cnt == PW'(DEPTH-1)) begin
          state_next = cqs_pkg::S_FIN;
        end
      end
      cqs_pkg::S_FIN: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = cqs_pkg::S_IDLE;
          case (cmd_q)
            cqs_pkg::CMD_ENQ: begin
              if (XW'(held) >= eff_cap) begin
                res_status = cqs_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                held_next = held + CW'(1);
                tail_next = advance(tail, eff_cap);
              end
            end
            cqs_pkg::CMD_DEQ: begin
              if (held == '0) begin
                res_status = cqs_pkg::ST_EMPTY;
              end else begin
                res_data  = wave[DEPTH].ud;
                held_next = held - CW'(1);
                head_next = advance(head, eff_cap);
              end
            end
            cqs_pkg::CMD_PEEK: begin
              if (held == '0) begin
                res_status = cqs_pkg::ST_EMPTY;
              end else begin
                res_data = wave[DEPTH].ud;
              end
            end
            cqs_pkg::CMD_SEARCH: begin
              if (wave[DEPTH].uf) begin
                res_slot = wave[DEPTH].us;
              end else if (wave[DEPTH].lf) begin
                res_slot = wave[DEPTH].ls;
              end else begin
                res_status = cqs_pkg::ST_NOTFOUND;
              end
            end
            cqs_pkg::CMD_CLEAR: begin
              head_next = '0;
              tail_next = '0;
              held_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: state_next = cqs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cqs_pkg::S_IDLE;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      walk_cnt  <= '0;
      capacity  <= RW'(DEPTH);
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      held     <= held_next;
      walk_cnt <= walk_cnt_next;
      if (cfg_wr_en) begin
        capacity <= RW'(cfg_wr_data);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd_in;
      value_q <= value;
      probe   <= probe_next;
    end
    if (load_out) begin
      status      <= res_status;
      data_out    <= res_data;
      match_slot  <= res_slot;
      entry_count <= held_next;
      is_empty    <= (held_next == '0);
      is_full     <= (XW'(held_next) >= eff_cap);
    end
  end

  assign wave[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cqs_cell #(
      .IDX     (i),
      .PW      (PW),
      .XW      (XW),
      .probe_t (probe_t),
      .wave_t  (wave_t)
    ) u_cell (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_slot  (tail),
      .wr_data  (value_q),
      .probe    (probe),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1])
    );
  end

endmodule

>>> hw/rtl/cqs_checker.sv
module cqs_checker #(
  parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [cqs_pkg::STATUS_W-1:0]        status,
  input logic signed [cqs_pkg::DATA_W-1:0]   data_out,
  input logic [$clog2(DEPTH)-1:0]            match_slot,
  input logic [$clog2(DEPTH+1)-1:0]          entry_count,
  input logic                                is_empty,
  input logic                                is_full
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> !is_full)
    else $error("empty queue reported full");

  a_full_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cqs_pkg::ST_FULL) |-> is_full && (data_out == 0))
    else $error("full status without full flag");

  a_empty_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cqs_pkg::ST_EMPTY) |-> is_empty && (data_out == 0)
      && (match_slot == '0))
    else $error("empty status on a held queue");

endmodule

bind circular_queue_with_search_core cqs_checker #(.DEPTH(DEPTH)) u_cqs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .data_out    (data_out),
  .match_slot  (match_slot),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .is_full     (is_full)
);
